[rtl/mspg_pkg.sv]
// Shared types, constants and the angle table of the servo pulse generator.
package mspg_pkg;

    localparam int NUM_CHANNELS_DEF  = 8;
    localparam int TABLE_ENTRIES_DEF = 181;
    localparam int ROM_SIZE          = 181;

    localparam int REQ_W     = 2;
    localparam int CHAN_W    = 3;
    localparam int ANGLE_W   = 10;
    localparam int PIN_W     = 8;
    localparam int PHASE_W   = 2;
    localparam int CMP_W     = 8;
    localparam int ROM_W     = 9;
    localparam int ROM_IDX_W = 8;
    localparam int CFG_W     = 8;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DETACH = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_MAX_ANGLE = 2'd0;

    localparam logic [CFG_W-1:0]   MAX_ANGLE_RESET = 8'd180;
    localparam logic [CMP_W-1:0]   COUNT_RESTART   = 8'd128;
    localparam logic [CMP_W-1:0]   COUNT_LAST      = 8'hFF;
    localparam logic [ROM_W-1:0]   COMPARE_MOD     = 9'd255;
    localparam logic [PHASE_W-1:0] PHASE_START     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_EARLY     = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LATE      = 2'd2;

    typedef struct packed {
        logic             en;
        logic             late;
        logic [CMP_W-1:0] cmp;
    } chan_entry_t;

    typedef struct packed {
        logic        we;
        chan_entry_t data;
    } chan_wr_t;

    localparam logic [ROM_W-1:0] ANGLE_ROM [ROM_SIZE] = '{
        9'd0,   9'd3,   9'd6,   9'd8,   9'd11,  9'd14,  9'd17,  9'd20,  9'd23,  9'd25,
        9'd28,  9'd31,  9'd34,  9'd37,  9'd40,  9'd42,  9'd45,  9'd48,  9'd51,  9'd54,
        9'd57,  9'd59,  9'd62,  9'd65,  9'd68,  9'd71,  9'd74,  9'd76,  9'd79,  9'd82,
        9'd85,  9'd88,  9'd91,  9'd93,  9'd96,  9'd99,  9'd102, 9'd105, 9'd107, 9'd110,
        9'd113, 9'd116, 9'd119, 9'd122, 9'd124, 9'd127, 9'd130, 9'd133, 9'd136, 9'd139,
        9'd141, 9'd144, 9'd147, 9'd150, 9'd153, 9'd156, 9'd158, 9'd161, 9'd164, 9'd167,
        9'd170, 9'd173, 9'd175, 9'd178, 9'd181, 9'd184, 9'd187, 9'd190, 9'd192, 9'd195,
        9'd198, 9'd201, 9'd204, 9'd206, 9'd209, 9'd212, 9'd215, 9'd218, 9'd221, 9'd223,
        9'd226, 9'd229, 9'd232, 9'd235, 9'd238, 9'd240, 9'd243, 9'd246, 9'd249, 9'd252,
        9'd254, 9'd257, 9'd260, 9'd263, 9'd266, 9'd269, 9'd272, 9'd274, 9'd277, 9'd280,
        9'd283, 9'd286, 9'd289, 9'd291, 9'd294, 9'd297, 9'd300, 9'd303, 9'd306, 9'd308,
        9'd311, 9'd314, 9'd317, 9'd320, 9'd322, 9'd325, 9'd328, 9'd331, 9'd334, 9'd337,
        9'd339, 9'd342, 9'd345, 9'd348, 9'd351, 9'd354, 9'd356, 9'd359, 9'd362, 9'd365,
        9'd368, 9'd371, 9'd373, 9'd376, 9'd379, 9'd382, 9'd385, 9'd388, 9'd390, 9'd393,
        9'd396, 9'd399, 9'd402, 9'd405, 9'd407, 9'd410, 9'd413, 9'd416, 9'd419, 9'd421,
        9'd424, 9'd427, 9'd430, 9'd433, 9'd436, 9'd438, 9'd441, 9'd444, 9'd447, 9'd450,
        9'd453, 9'd455, 9'd458, 9'd461, 9'd464, 9'd467, 9'd470, 9'd472, 9'd475, 9'd478,
        9'd481, 9'd484, 9'd487, 9'd489, 9'd492, 9'd495, 9'd498, 9'd501, 9'd504, 9'd506,
        9'd509
    };

endpackage

[rtl/mspg_if.sv]
// Request and response channel interfaces of the servo pulse generator.
interface mspg_req_if;
    logic                         valid;
    logic                         ready;
    logic [mspg_pkg::REQ_W-1:0]   req_type;
    logic [mspg_pkg::CHAN_W-1:0]  channel_index;
    logic [mspg_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output req_type, output channel_index, output angle,
                    input ready);
    modport sink (input valid, input req_type, input channel_index, input angle,
                  output ready);
endinterface

interface mspg_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mspg_pkg::PIN_W-1:0]   pin_levels;
    logic [mspg_pkg::CHAN_W-1:0]  active_channel;
    logic [mspg_pkg::PHASE_W-1:0] slot_phase;

    modport source (output valid, output pin_levels, output active_channel,
                    output slot_phase, input ready);
    modport sink (input valid, input pin_levels, input active_channel,
                  input slot_phase, output ready);
endinterface

[rtl/multiplexed_servo_pulse_generator.sv]
// Top level of the time-multiplexed servo pulse generator.
//
// Usage: each beat on req is one request. A tick beat advances the shared 8-bit
// counter; a write beat maps an angle to a pulse length and enables a channel;
// a detach beat drops and disables a channel. Every request beat yields exactly
// one beat on rsp carrying the pin levels, the running channel and its phase.
// A request passes the middle stage and the response register: the per-channel
// memory is read in the accept cycle and the pin update is registered into the
// response stage. While rsp does not stall, one request is taken every cycle;
// a tick uses the single read port of the channel memory once per beat.
// When rsp stalls, the middle stage and the response register each hold one
// beat; req.ready drops once both are full, and nothing is lost.
// Reset clears all channels (disabled, pins low), the counter to 0, the slot to
// channel 0 and the phase to 2, and sets max_angle to 180. max_angle (APB byte
// address 0) must be written only while no request is in flight; no guard enforces it.
module multiplexed_servo_pulse_generator #(
    parameter int NUM_CHANNELS  = mspg_pkg::NUM_CHANNELS_DEF,
    parameter int TABLE_ENTRIES = mspg_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mspg_pkg::PADDR_W-1:0]  paddr,
    input  logic [mspg_pkg::PDATA_W-1:0]  pwdata,
    output logic [mspg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    mspg_req_if.sink                      req,
    mspg_rsp_if.source                    rsp
);

    localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW     = mspg_pkg::PIN_W;
    localparam int CW     = mspg_pkg::CHAN_W;
    localparam int DW     = mspg_pkg::PDATA_W;
    localparam int FW     = mspg_pkg::CFG_W;
    localparam int TW     = mspg_pkg::CMP_W;
    localparam int HW     = mspg_pkg::PHASE_W;

    logic [FW-1:0]     max_angle_reg;
    logic [TW-1:0]     tick_reg;
    logic [HW-1:0]     phase_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PW-1:0]     levels_reg;

    logic              b_valid_reg;
    logic [mspg_pkg::REQ_W-1:0] b_req_reg;
    logic [SLOT_W-1:0] b_chan_reg;
    logic              b_chan_ok_reg;
    logic              b_enter_reg;
    logic [SLOT_W-1:0] b_old_slot_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    logic [HW-1:0]     b_phase_reg;
    logic [TW-1:0]     b_tick_reg;

    logic              out_valid_reg;
    logic [PW-1:0]     out_pins_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [HW-1:0]     out_phase_reg;

    logic              out_adv;
    logic              b_adv;
    logic              accept;
    logic              is_tick;
    logic              chan_ok;
    logic              wrap;
    logic              enter;
    logic [HW-1:0]     phase_next;
    logic [SLOT_W-1:0] slot_next;
    logic [TW-1:0]     tick_next;
    logic [PW-1:0]     levels_next;
    logic              cfg_wr;

    mspg_pkg::chan_entry_t map_entry;
    mspg_pkg::chan_entry_t rd_entry;
    mspg_pkg::chan_wr_t    mem_wr;

    function automatic logic [PW-1:0] pin_put(input logic [PW-1:0] lv,
                                              input logic [SLOT_W-1:0] idx,
                                              input logic val);
        logic [PW-1:0] r;
        r = lv;
        for (int i = 0; i < PW; i++)
        begin
            if (32'(idx) == i)
            begin
                r[i] = val;
            end
        end
        return r;
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == mspg_pkg::ADDR_MAX_ANGLE);
    assign prdata = (paddr == mspg_pkg::ADDR_MAX_ANGLE) ? DW'(max_angle_reg) : '0;

    // Handshake.
    assign out_adv   = !out_valid_reg || rsp.ready;
    assign b_adv     = b_valid_reg && out_adv;
    assign req.ready = !b_valid_reg || out_adv;
    assign accept    = req.valid && req.ready;
    assign is_tick   = (req.req_type == mspg_pkg::REQ_TICK);
    assign chan_ok   = (32'(req.channel_index) < NUM_CHANNELS);

    // Counter, phase and slot sequencing for a tick.
    always_comb
    begin
        wrap       = (tick_reg == mspg_pkg::COUNT_LAST);
        phase_next = phase_reg;
        if (wrap)
        begin
            phase_next = (phase_reg >= mspg_pkg::PHASE_LATE) ? mspg_pkg::PHASE_START
                                                             : phase_reg + 1'b1;
        end
        enter     = wrap && (phase_next == mspg_pkg::PHASE_START);
        slot_next = slot_reg;
        tick_next = tick_reg + 1'b1;
        if (enter)
        begin
            slot_next = (32'(slot_reg) >= NUM_CHANNELS - 1) ? '0 : slot_reg + 1'b1;
            tick_next = mspg_pkg::COUNT_RESTART;
        end
    end

    mspg_angle_map #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_map (
        .angle     (req.angle),
        .max_angle (max_angle_reg),
        .entry     (map_entry)
    );

    // A detach stores a disabled entry; compare and late are then don't-care.
    always_comb
    begin
        mem_wr.we   = accept && chan_ok && ((req.req_type == mspg_pkg::REQ_WRITE) ||
                                            (req.req_type == mspg_pkg::REQ_DETACH));
        mem_wr.data = (req.req_type == mspg_pkg::REQ_WRITE) ? map_entry : '0;
    end

    mspg_chan_mem #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mem_wr),
        .waddr (SLOT_W'(req.channel_index)),
        .re    (accept && is_tick),
        .raddr (slot_next),
        .rdata (rd_entry)
    );

    // Pin update. A disabled channel's pin is always low, so drops need no
    // enable check except on a compare match.
    always_comb
    begin
        levels_next = levels_reg;
        case (b_req_reg)
            mspg_pkg::REQ_TICK:
            begin
                if (b_enter_reg)
                begin
                    levels_next = pin_put(levels_next, b_old_slot_reg, 1'b0);
                    if (rd_entry.en)
                    begin
                        levels_next = pin_put(levels_next, b_slot_reg, 1'b1);
                    end
                end
                if (rd_entry.en && (b_tick_reg == rd_entry.cmp) &&
                    (((b_phase_reg == mspg_pkg::PHASE_EARLY) && !rd_entry.late) ||
                     ((b_phase_reg == mspg_pkg::PHASE_LATE) && rd_entry.late)))
                begin
                    levels_next = pin_put(levels_next, b_slot_reg, 1'b0);
                end
            end
            mspg_pkg::REQ_DETACH:
            begin
                if (b_chan_ok_reg)
                begin
                    levels_next = pin_put(levels_next, b_chan_reg, 1'b0);
                end
            end
            default:
            begin
                levels_next = levels_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg <= mspg_pkg::MAX_ANGLE_RESET;
            tick_reg      <= '0;
            phase_reg     <= mspg_pkg::PHASE_LATE;
            slot_reg      <= '0;
            levels_reg    <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                max_angle_reg <= pwdata[FW-1:0];
            end
            if (accept && is_tick)
            begin
                tick_reg  <= tick_next;
                phase_reg <= phase_next;
                slot_reg  <= slot_next;
            end
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                levels_reg    <= levels_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_req_reg      <= req.req_type;
            b_chan_reg     <= SLOT_W'(req.channel_index);
            b_chan_ok_reg  <= chan_ok;
            b_enter_reg    <= is_tick && enter;
            b_old_slot_reg <= slot_reg;
            b_slot_reg     <= is_tick ? slot_next : slot_reg;
            b_phase_reg    <= is_tick ? phase_next : phase_reg;
            b_tick_reg     <= is_tick ? tick_next : tick_reg;
        end
        if (b_adv)
        begin
            out_pins_reg  <= levels_next;
            out_slot_reg  <= b_slot_reg;
            out_phase_reg <= b_phase_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.pin_levels     = out_pins_reg;
    assign rsp.active_channel = CW'(out_slot_reg);
    assign rsp.slot_phase     = out_phase_reg;

    // A slot start restarts the count at mid-range.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick && (tick_reg == mspg_pkg::COUNT_LAST) &&
         (phase_reg == mspg_pkg::PHASE_LATE))
        |=> (tick_reg == mspg_pkg::COUNT_RESTART) && (phase_reg == mspg_pkg::PHASE_START))
        else $error("slot start did not restart the counter");

    // A waiting item in the middle stage is never dropped.
    a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !out_adv) |=> b_valid_reg && $stable(b_slot_reg))
        else $error("middle stage lost an item");

    // At most one servo pin is high at a time.
    a_one_pin: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(levels_reg))
        else $error("more than one servo pin high");

    // A tick that does not wrap advances the counter by one.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick && (tick_reg != mspg_pkg::COUNT_LAST))
        |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick counter skipped");

endmodule

[rtl/mspg_angle_map.sv]
// Angle clamp, table lookup and split into compare byte and late flag.
module mspg_angle_map #(
    parameter int TABLE_ENTRIES = mspg_pkg::TABLE_ENTRIES_DEF
) (
    input  logic [mspg_pkg::ANGLE_W-1:0] angle,
    input  logic [mspg_pkg::CFG_W-1:0]   max_angle,
    output mspg_pkg::chan_entry_t        entry
);

    localparam int ROM_LAST = ((TABLE_ENTRIES > mspg_pkg::ROM_SIZE) ?
                               mspg_pkg::ROM_SIZE : TABLE_ENTRIES) - 1;
    localparam int AW = mspg_pkg::ANGLE_W;
    localparam int IW = mspg_pkg::ROM_IDX_W;
    localparam int CW = mspg_pkg::CMP_W;

    logic [AW-1:0]               ang_sat;
    logic [AW-1:0]               ang_lim;
    logic [IW-1:0]               rom_idx;
    logic [mspg_pkg::ROM_W-1:0]  rom_val;
    logic [mspg_pkg::ROM_W-1:0]  rom_wrap;

    always_comb
    begin
        ang_sat  = (angle > AW'(max_angle)) ? AW'(max_angle) : angle;
        ang_lim  = (ang_sat > AW'(ROM_LAST)) ? AW'(ROM_LAST) : ang_sat;
        rom_idx  = ang_lim[IW-1:0];
        rom_val  = mspg_pkg::ANGLE_ROM[rom_idx];
        rom_wrap = rom_val - mspg_pkg::COMPARE_MOD;
        // Table values stay below twice the modulus: one subtract is enough.
        entry.en   = 1'b1;
        entry.late = (rom_val >= mspg_pkg::COMPARE_MOD);
        entry.cmp  = entry.late ? rom_wrap[CW-1:0] : rom_val[CW-1:0];
    end

endmodule

[rtl/mspg_chan_mem.sv]
// Per-channel state memory: one write and one registered read per cycle.
module mspg_chan_mem #(
    parameter int NUM_CHANNELS = mspg_pkg::NUM_CHANNELS_DEF,
    localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mspg_pkg::chan_wr_t    wr,
    input  logic [SLOT_W-1:0]     waddr,
    input  logic                  re,
    input  logic [SLOT_W-1:0]     raddr,
    output mspg_pkg::chan_entry_t rdata
);

    mspg_pkg::chan_entry_t       mem_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]     valid_reg;
    mspg_pkg::chan_entry_t       rd_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[waddr] <= wr.data;
        end
        if (re)
        begin
            rd_reg <= mem_reg[raddr];
        end
    end

    // Entries never written since reset read as cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule
